// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the subnet route table engine.
// Expects signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/srte_pkg.sv =====
// Types, codes and sizes for the subnet route table engine.
// No dependencies; imported by every module of the block.
package srte_pkg;

   localparam int NUM_SUBNETS = 64;
   localparam int NUM_IFACES  = 4;
   localparam int SUB_W       = (NUM_SUBNETS > 1) ? $clog2(NUM_SUBNETS) : 1;

   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_PRIMARY_VALID = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRIMARY_ADDR  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_DATA_LEN  = 2'd2;

   localparam logic [11:0] MAX_DATA_LEN_RESET = 12'd488;

   localparam logic [1:0] OP_SET_DIRECT = 2'd0;
   localparam logic [1:0] OP_CLEAR      = 2'd1;
   localparam logic [1:0] OP_UPDATE     = 2'd2;
   localparam logic [1:0] OP_ROUTE      = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_DIRECT = 2'd1;
   localparam logic [1:0] KIND_BRIDGE = 2'd2;
   localparam logic [1:0] KIND_FIXED  = 2'd3;

   localparam logic [3:0] ST_ACK      = 4'd0;
   localparam logic [3:0] ST_NAK      = 4'd1;
   localparam logic [3:0] ST_LOCAL    = 4'd2;
   localparam logic [3:0] ST_FORWARD  = 4'd3;
   localparam logic [3:0] ST_LEN      = 4'd4;
   localparam logic [3:0] ST_REJECT   = 4'd5;
   localparam logic [3:0] ST_OVERFWD  = 4'd6;
   localparam logic [3:0] ST_NOROUTE  = 4'd7;
   localparam logic [3:0] ST_IGNORED  = 4'd8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK1,
      S_LOOK2
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] cost;
      logic [15:0] path;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [SUB_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic             en;
      logic [SUB_W-1:0] addr;
      entry_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  subnet;
      logic [3:0]  iface;
      logic [15:0] cost;
      logic [15:0] source_addr;
      logic [15:0] dest_addr;
      logic        from_device;
      logic [3:0]  fwd_count;
      logic [11:0] data_len;
   } item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  out_iface;
      logic [15:0] next_hop;
      logic        broadcast;
      logic [15:0] new_dest;
      logic [3:0]  new_fwd_count;
   } rsp_type;

   typedef struct packed {
      logic        primary_valid;
      logic [15:0] primary_addr;
      logic [11:0] max_data_len;
   } cfg_type;

   function automatic logic sub_oor(logic [7:0] sn);
      return {1'b0, sn} >= 9'(NUM_SUBNETS);
   endfunction

endpackage

// ===== hdl/subnet_route_table_engine_top.sv =====
// An accepted word passes S_LOOK1, then S_LOOK2, which holds on a stalled output.
// The result word is registered as S_LOOK2 ends, and the next word is taken then,
// as the two dependent reads (entry, then bridge entry) share one table read port.
// Reset: synchronous, active high; table valid bits clear at once (no sweep),
// registers return to primary_valid 0, primary_addr 0, max_data_len 488.
module subnet_route_table_engine_top
   import srte_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // subnet, iface, cost, source_addr, dest_addr, from_device, fwd_count, data_len
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  logic [1:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // status, out_iface, next_hop, broadcast, new_dest, new_fwd_count
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type    cfg_ff;
   item_type   req_item;
   rsp_type    rsp;
   mem_rd_type mem_rd;
   mem_wr_type mem_wr;
   entry_type  mem_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.primary_valid <= 1'b0;
         cfg_ff.primary_addr  <= 16'd0;
         cfg_ff.max_data_len  <= MAX_DATA_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PRIMARY_VALID: cfg_ff.primary_valid <= csr_wdata[0];
            CSR_PRIMARY_ADDR:  cfg_ff.primary_addr  <= csr_wdata;
            CSR_MAX_DATA_LEN:  cfg_ff.max_data_len  <= csr_wdata[11:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_item.opcode      = req_tuser;
      req_item.subnet      = req_tdata[7:0];
      req_item.iface       = req_tdata[11:8];
      req_item.cost        = req_tdata[27:12];
      req_item.source_addr = req_tdata[43:28];
      req_item.dest_addr   = req_tdata[59:44];
      req_item.from_device = req_tdata[60];
      req_item.fwd_count   = req_tdata[64:61];
      req_item.data_len    = req_tdata[76:65];
   end

   assign rsp_tdata = {3'b000, rsp.new_fwd_count, rsp.new_dest, rsp.broadcast,
                       rsp.next_hop, rsp.out_iface, rsp.status};

   srte_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .mem_rd    (mem_rd),
      .mem_wr    (mem_wr),
      .mem_data  (mem_data)
   );

   srte_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd      (mem_rd),
      .wr      (mem_wr),
      .rd_data (mem_data)
   );

endmodule

// ===== hdl/srte_table.sv =====
// Route table memory: one entry per subnet, registered read, one write port.
// Valid bits give the cleared value after reset; same-cycle write is forwarded.
module srte_table
   import srte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mem_rd_type rd,
   input  mem_wr_type wr,
   output entry_type  rd_data
);

   entry_type               mem [NUM_SUBNETS];
   logic [NUM_SUBNETS-1:0]  valid_ff;
   entry_type               rd_mem_ff;
   entry_type               rd_byp_data_ff;
   logic                    rd_byp_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_mem_ff      <= mem[rd.addr];
         rd_vld_ff      <= valid_ff[rd.addr];
         rd_byp_ff      <= wr.en && (wr.addr == rd.addr);
         rd_byp_data_ff <= wr.data;
      end
   end

   always_comb begin
      if (rd_byp_ff) begin
         rd_data = rd_byp_data_ff;
      end else if (rd_vld_ff) begin
         rd_data = rd_mem_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ===== hdl/srte_seq.sv =====
// Sequencer: two dependent table reads per word, then decision and write-back.
// Uses srte_pkg and drives the srte_table ports; holds the result register.
module srte_seq
   import srte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  item_type   req_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp,
   output mem_rd_type mem_rd,
   output mem_wr_type mem_wr,
   input  entry_type  mem_data
);

`include "assert_macros.svh"

   seq_state_type state_ff, state_in;
   item_type      item_ff;
   entry_type     ent1_ff;
   logic [15:0]   hop_ff, hop_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;
   logic          out_free;
   logic          accept;
   logic          done;
   logic [7:0]    rd_sub;
   logic [3:0]    nfc;
   logic          prim_hit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_LOOK1;
         S_LOOK1: state_in = S_LOOK2;
         S_LOOK2: begin
            if (out_free) begin
               state_in = req_valid ? S_LOOK1 : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_LOOK1: req_ready = 1'b0;
         S_LOOK2: begin
            req_ready = out_free;
            done      = out_free;
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // second lookup for routes: the bridge for bridge/fixed routes, else the destination
   always_comb begin
      if (mem_data.kind == KIND_BRIDGE || mem_data.kind == KIND_FIXED) begin
         hop_in = mem_data.path;
      end else begin
         hop_in = item_ff.dest_addr;
      end
   end

   always_comb begin
      rd_sub = item_ff.subnet;
      if (accept) begin
         case (req_item.opcode)
            OP_UPDATE: rd_sub = req_item.source_addr[15:8];
            OP_ROUTE:  rd_sub = req_item.dest_addr[15:8];
            default:   rd_sub = req_item.subnet;
         endcase
      end else if (item_ff.opcode == OP_ROUTE) begin
         rd_sub = hop_in[15:8];
      end
      mem_rd.en   = accept || (state_ff == S_LOOK1);
      mem_rd.addr = rd_sub[SUB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (state_ff == S_LOOK1) begin
         ent1_ff <= mem_data;
         hop_ff  <= hop_in;
      end
   end

   assign nfc      = item_ff.fwd_count + 4'd1;
   assign prim_hit = cfg.primary_valid &&
                     (item_ff.dest_addr == cfg.primary_addr ||
                      (item_ff.from_device && item_ff.dest_addr == 16'd0));

   always_comb begin
      rsp_in       = '0;
      mem_wr.en    = 1'b0;
      mem_wr.addr  = item_ff.subnet[SUB_W-1:0];
      mem_wr.data  = mem_data;
      unique case (item_ff.opcode)
         OP_SET_DIRECT: begin
            if (item_ff.subnet == 8'd0 || sub_oor(item_ff.subnet) ||
                {1'b0, item_ff.iface} >= 5'(NUM_IFACES)) begin
               rsp_in.status = ST_NAK;
            end else begin
               rsp_in.status    = ST_ACK;
               mem_wr.en        = done;
               mem_wr.data.kind = KIND_DIRECT;
               mem_wr.data.cost = item_ff.cost;
               mem_wr.data.path = 16'(item_ff.iface);
            end
         end
         OP_CLEAR: begin
            if (sub_oor(item_ff.subnet)) begin
               rsp_in.status = ST_NAK;
            end else begin
               rsp_in.status    = ST_ACK;
               mem_wr.en        = done;
               mem_wr.data.kind = KIND_NONE;
            end
         end
         OP_UPDATE: begin
            if (sub_oor(item_ff.source_addr[15:8]) || ent1_ff.kind != KIND_DIRECT ||
                sub_oor(item_ff.subnet)) begin
               rsp_in.status = ST_IGNORED;
            end else begin
               rsp_in.status = ST_ACK;
               if (mem_data.kind == KIND_NONE ||
                   (mem_data.kind == KIND_BRIDGE && item_ff.cost <= mem_data.cost)) begin
                  mem_wr.en        = done;
                  mem_wr.data.kind = KIND_BRIDGE;
                  mem_wr.data.cost = item_ff.cost;
                  mem_wr.data.path = item_ff.source_addr;
               end
            end
         end
         OP_ROUTE: begin
            if (prim_hit) begin
               if (item_ff.data_len > cfg.max_data_len) begin
                  rsp_in.status = ST_LEN;
               end else begin
                  rsp_in.status        = ST_LOCAL;
                  rsp_in.new_dest      = cfg.primary_addr;
                  rsp_in.new_fwd_count = item_ff.fwd_count;
               end
            end else if (item_ff.from_device && item_ff.dest_addr[7:0] == 8'd0) begin
               rsp_in.status = ST_REJECT;
            end else if (item_ff.from_device && nfc == 4'd0) begin
               rsp_in.status = ST_OVERFWD;
            end else if (sub_oor(item_ff.dest_addr[15:8]) || ent1_ff.kind == KIND_NONE) begin
               rsp_in.status = ST_NOROUTE;
            end else if (sub_oor(hop_ff[15:8]) || mem_data.kind != KIND_DIRECT) begin
               rsp_in.status = ST_NOROUTE;
            end else begin
               rsp_in.status        = ST_FORWARD;
               rsp_in.out_iface     = mem_data.path[3:0];
               rsp_in.next_hop      = hop_ff;
               rsp_in.broadcast     = (hop_ff[7:0] == 8'd0);
               rsp_in.new_dest      = (item_ff.dest_addr[7:0] == 8'd0) ? 16'd0
                                                                      : item_ff.dest_addr;
               rsp_in.new_fwd_count = item_ff.from_device ? nfc : item_ff.fwd_count;
            end
         end
         default: rsp_in.status = ST_NAK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   `ASSERT_IMPLIES(a_wr_at_done, mem_wr.en, state_ff == S_LOOK2 && out_free)
   `ASSERT_NEXT(a_accept_look1, req_valid && req_ready, state_ff == S_LOOK1)
   `ASSERT_NEXT(a_done_loads_rsp, state_ff == S_LOOK2 && out_free, rsp_valid_ff)
   `ASSERT_IMPLIES(a_stall_no_read, state_ff == S_LOOK2 && !out_free, !mem_rd.en)

endmodule
